FILE: rtl/held_key_tracker_core_assert.svh
// Assertion macros shared by the held key tracker checker.
// Expects clk and arst_n in the scope where the macros are used.
`ifndef HELD_KEY_TRACKER_CORE_ASSERT_SVH
`define HELD_KEY_TRACKER_CORE_ASSERT_SVH

// same-cycle implication
`define HKT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HKT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/hkt_pkg.sv
// Package for the held key tracker: sizes, event kinds, controller states
// and the command bundle broadcast to the key cells. No dependencies.
`default_nettype none

package hkt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int PRESS_BIT   = 15;

	localparam int KEY_W  = 16;
	localparam int MOD_W  = 16;
	localparam int KIND_W = 3;
	localparam int HELD_W = 5;
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

	localparam int IN_W  = KEY_W + MOD_W;
	localparam int OUT_W = ((KIND_W + KEY_W + 2 * MOD_W + HELD_W + 7) / 8) * 8;

	typedef enum logic [KIND_W-1:0] {
		KIND_NEW            = 3'd0,
		KIND_REPEAT         = 3'd1,
		KIND_SUPPRESSED     = 3'd2,
		KIND_RELEASE        = 3'd3,
		KIND_RELEASE_UNHELD = 3'd4,
		KIND_DROPPED        = 3'd5
	} kind_t;

	typedef enum logic {
		ST_IDLE,
		ST_LOOK
	} state_t;

	// broadcast to every cell while an event is looked up
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [MOD_W-1:0] mods;
		logic             press;
		logic             repeat_en;
		logic             any_hit;
		logic             commit;
	} cell_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/hkt_cell.sv
// One slot of the held key table: valid flag, key code and press modifiers.
// Free-slot claim and stored-modifier readout ripple along the chain. Uses hkt_pkg.
`default_nettype none

module hkt_cell
	import hkt_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cell_cmd_t        cmd,
	input  wire logic             free_in,   // a lower slot is already free
	input  wire logic [MOD_W-1:0] pm_in,
	output logic                  hit,
	output logic                  free_out,
	output logic      [MOD_W-1:0] pm_out
);

	logic             valid_q;
	logic [KEY_W-1:0] key_q;
	logic [MOD_W-1:0] mods_q;
	logic             claim;
	logic             upd_mods;

	assign hit      = valid_q && (key_q == cmd.key);
	assign free_out = free_in || !valid_q;
	assign pm_out   = pm_in | (hit ? mods_q : '0);

	// lowest free slot takes a new press
	assign claim    = cmd.commit && cmd.press && !cmd.any_hit && !valid_q && !free_in;
	assign upd_mods = cmd.commit && hit && cmd.press && cmd.repeat_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (claim) begin
			valid_q <= 1'b1;
		end else if (cmd.commit && hit && !cmd.press) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (claim) begin
			key_q <= cmd.key;
		end
		if (claim || upd_mods) begin
			mods_q <= cmd.mods;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/held_key_tracker_core.sv
// Held key tracker: a chain of TABLE_DEPTH key cells and the event controller
// with its output register. Uses hkt_pkg and hkt_cell.
//
// Each key event is registered when taken and resolved in the look-up state
// once the result register is free: all cells compare the key at once, the
// lowest free slot is found by a ripple along the cell chain, and the table,
// count and result register are updated together. A new event is accepted
// only after the previous one has been resolved. One result is produced per
// event. Reset clears all valid flags at once; no clearing pass.
`default_nettype none

module held_key_tracker_core
	import hkt_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wen,
	input  wire logic             cfg_wdata,     // repeat_enable
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire logic [IN_W-1:0]  s_axis_tdata,  // key_code, modifier_word
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	output logic      [OUT_W-1:0] m_axis_tdata   // event_kind, event_key,
	                                             // stored_modifiers,
	                                             // current_modifiers, held_count
);

	state_t           state_q, state_nxt;
	logic             repeat_en_q;
	logic [KEY_W-1:0] key_s1;
	logic [MOD_W-1:0] mods_s1;
	logic [CNT_W-1:0] cnt_q, cnt_nxt;
	logic             m_valid_q;
	logic [OUT_W-1:0] m_data_q;

	logic             out_free, commit, take, press, any_hit, any_free;
	kind_t            kind;
	logic [MOD_W-1:0] pmods;
	cell_cmd_t        cmd;

	logic [TABLE_DEPTH-1:0] hit;
	logic [TABLE_DEPTH:0]   free_chain;
	logic [MOD_W-1:0]       pm_chain [TABLE_DEPTH+1];

	assign out_free = !m_valid_q || m_axis_tready;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (s_axis_tvalid) state_nxt = ST_LOOK;
			ST_LOOK: if (out_free)      state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// controller outputs
	always_comb begin
		s_axis_tready = 1'b0;
		commit        = 1'b0;
		unique case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_LOOK: commit        = out_free;
			default: ;
		endcase
	end

	assign take = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			repeat_en_q <= 1'b1;
		end else begin
			state_q <= state_nxt;
			if (cfg_wen) begin
				repeat_en_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			key_s1  <= s_axis_tdata[KEY_W-1:0];
			mods_s1 <= s_axis_tdata[KEY_W +: MOD_W];
		end
	end

	assign press   = mods_s1[PRESS_BIT];
	assign any_hit = |hit;
	assign any_free = free_chain[TABLE_DEPTH];

	assign cmd = '{key: key_s1, mods: mods_s1, press: press, repeat_en: repeat_en_q,
		any_hit: any_hit, commit: commit};

	assign free_chain[0] = 1'b0;
	assign pm_chain[0]   = '0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		hkt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.free_in (free_chain[i]),
			.pm_in   (pm_chain[i]),
			.hit     (hit[i]),
			.free_out(free_chain[i+1]),
			.pm_out  (pm_chain[i+1])
		);
	end

	always_comb begin
		if (!any_hit) begin
			if (press) kind = any_free ? KIND_NEW : KIND_DROPPED;
			else       kind = KIND_RELEASE_UNHELD;
		end else begin
			if (press) kind = repeat_en_q ? KIND_REPEAT : KIND_SUPPRESSED;
			else       kind = KIND_RELEASE;
		end
	end

	always_comb begin
		pmods   = '0;
		cnt_nxt = cnt_q;
		case (kind)
			KIND_NEW: begin
				pmods   = mods_s1;
				cnt_nxt = cnt_q + CNT_W'(1);
			end
			KIND_REPEAT:     pmods = mods_s1;
			KIND_SUPPRESSED: pmods = pm_chain[TABLE_DEPTH];
			KIND_RELEASE: begin
				pmods = pm_chain[TABLE_DEPTH];
				if (cnt_q != '0) cnt_nxt = cnt_q - CNT_W'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else if (commit) begin
			cnt_q     <= cnt_nxt;
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			m_data_q <= OUT_W'({HELD_W'(cnt_nxt), mods_s1, pmods, key_s1, kind});
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

FILE: rtl/hkt_checker.sv
// Port-level checker for held_key_tracker_core, bound to the top level.
// Uses hkt_pkg and the macros in held_key_tracker_core_assert.svh.
`default_nettype none
`include "held_key_tracker_core_assert.svh"

module hkt_checker
	import hkt_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             m_axis_tvalid,
	input wire logic             m_axis_tready,
	input wire logic [OUT_W-1:0] m_axis_tdata
);

	localparam int PM_LO  = KIND_W + KEY_W;
	localparam int CUR_LO = PM_LO + MOD_W;

	logic [KIND_W-1:0] kind;
	logic [MOD_W-1:0]  pm, cur;

	assign kind = m_axis_tdata[KIND_W-1:0];
	assign pm   = m_axis_tdata[PM_LO +: MOD_W];
	assign cur  = m_axis_tdata[CUR_LO +: MOD_W];

	`HKT_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

	`HKT_ASSERT_NOW(a_fresh_mods, m_axis_tvalid && (kind == KIND_NEW || kind == KIND_REPEAT),
		pm == cur, "stored modifiers differ from a fresh press")

	`HKT_ASSERT_NOW(a_zero_mods,
		m_axis_tvalid && (kind == KIND_RELEASE_UNHELD || kind == KIND_DROPPED),
		pm == '0, "unheld key reported with modifiers")

	`HKT_ASSERT_NOW(a_press_kind, m_axis_tvalid && cur[PRESS_BIT],
		kind == KIND_NEW || kind == KIND_REPEAT || kind == KIND_SUPPRESSED ||
		kind == KIND_DROPPED, "press reported as a release")

	`HKT_ASSERT_NOW(a_release_kind, m_axis_tvalid && !cur[PRESS_BIT],
		kind == KIND_RELEASE || kind == KIND_RELEASE_UNHELD, "release reported as a press")

endmodule

bind held_key_tracker_core hkt_checker u_hkt_checker (.*);

`default_nettype wire

FILE: tb/held_key_tracker_core_test.sv
// Self-checking bench for held_key_tracker_core: streams key events, predicts each result
// from its own copy of the held key table and checks every output transaction.
// Depends on hkt_pkg and the RTL of held_key_tracker_core only.
`timescale 1ns / 1ps

module held_key_tracker_core_test
	import hkt_pkg::*;
();

	localparam int RESET_CYCLES   = 12;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SINK_HOLD      = 300;
	localparam int KEY_POOL_SZ    = 24;

	typedef struct packed {
		logic [MOD_W-1:0] mods;
		logic [KEY_W-1:0] key;
	} key_event_t;

	typedef struct packed {
		logic [HELD_W-1:0] held;
		logic [MOD_W-1:0]  cur_mods;
		logic [MOD_W-1:0]  stored_mods;
		logic [KEY_W-1:0]  key;
		kind_t             kind;
	} key_report_t;

	logic             clk           = 1'b0;
	logic             arst_n        = 1'b0;
	logic             cfg_wen       = 1'b0;
	logic             cfg_wdata     = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata  = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	held_key_tracker_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// table copy used for prediction
	logic              slot_used [TABLE_DEPTH];
	logic [KEY_W-1:0]  slot_key  [TABLE_DEPTH];
	logic [MOD_W-1:0]  slot_mods [TABLE_DEPTH];
	int                held_total = 0;
	bit                repeat_on  = 1'b1;

	key_event_t  pending_events[$];
	key_report_t expected_reports[$];
	logic [KEY_W-1:0] key_pool [KEY_POOL_SZ];

	int  send_idle_pct = 0;
	int  sink_idle_pct = 0;
	int  error_count   = 0;
	int  results_seen  = 0;
	int  idle_cycles   = 0;
	int  stall_at      = 32'h7fffffff;
	int  hold_cnt      = 0;
	bit  stall_done    = 1'b0;
	bit  in_fire       = 1'b0;

	function automatic key_report_t predict_key_report(key_event_t ev);
		key_report_t r;
		int hit;
		int free_slot;
		logic press;
		press     = ev.mods[PRESS_BIT];
		hit       = -1;
		free_slot = -1;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (hit < 0 && slot_used[i] && slot_key[i] == ev.key)
				hit = i;
			if (free_slot < 0 && !slot_used[i])
				free_slot = i;
		end
		r.key         = ev.key;
		r.cur_mods    = ev.mods;
		r.stored_mods = '0;
		if (hit < 0) begin
			if (!press) begin
				r.kind = KIND_RELEASE_UNHELD;
			end else if (free_slot < 0) begin
				r.kind = KIND_DROPPED;
			end else begin
				slot_used[free_slot] = 1'b1;
				slot_key[free_slot]  = ev.key;
				slot_mods[free_slot] = ev.mods;
				held_total++;
				r.kind        = KIND_NEW;
				r.stored_mods = ev.mods;
			end
		end else if (press) begin
			if (repeat_on) begin
				slot_mods[hit] = ev.mods;
				r.kind         = KIND_REPEAT;
				r.stored_mods  = ev.mods;
			end else begin
				r.kind        = KIND_SUPPRESSED;
				r.stored_mods = slot_mods[hit];
			end
		end else begin
			r.stored_mods  = slot_mods[hit];
			slot_used[hit] = 1'b0;
			if (held_total > 0)
				held_total--;
			r.kind = KIND_RELEASE;
		end
		r.held = held_total[HELD_W-1:0];
		return r;
	endfunction

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			error_count++;
		end
	endtask

	// driver: tvalid only drops once the current transaction has gone
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || in_fire) begin
			if (pending_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				s_axis_tdata  <= pending_events.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// sink: random back-pressure plus one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			m_axis_tready <= 1'b0;
			hold_cnt--;
		end else if (!stall_done && results_seen >= stall_at) begin
			m_axis_tready <= 1'b0;
			hold_cnt      = SINK_HOLD;
			stall_done    = 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// monitor and scoreboard
	always @(posedge clk) begin
		key_report_t want;
		key_report_t got;
		logic in_now;
		logic out_now;
		in_now  = s_axis_tvalid && s_axis_tready;
		out_now = m_axis_tvalid && m_axis_tready;
		if (arst_n) begin
			in_fire <= in_now;
			if (in_now)
				expected_reports.push_back(predict_key_report(key_event_t'(s_axis_tdata)));
			if (out_now) begin
				got = key_report_t'(m_axis_tdata);
				if (expected_reports.size() == 0) begin
					$display("%0t: unexpected transaction, expected none, actual %h",
						$time, m_axis_tdata);
					error_count++;
				end else begin
					want = expected_reports.pop_front();
					check_field("event_kind", 16'(want.kind), 16'(got.kind));
					check_field("event_key", want.key, got.key);
					check_field("stored_modifiers", want.stored_mods, got.stored_mods);
					check_field("current_modifiers", want.cur_mods, got.cur_mods);
					check_field("held_count", 16'(want.held), 16'(got.held));
				end
				results_seen <= results_seen + 1;
			end
			idle_cycles <= (in_now || out_now) ? 0 : idle_cycles + 1;
		end
	end

	initial begin
		wait (arst_n);
		while (idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// checked at the rising edge, where the driver never pops the queue
	task automatic wait_for_drain();
		do
			@(posedge clk);
		while (pending_events.size() != 0 || s_axis_tvalid || expected_reports.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_repeat_enable(bit v);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_wen   <= 1'b0;
		repeat_on = v;
		@(posedge clk);
	endtask

	task automatic queue_key(logic [KEY_W-1:0] key, logic [MOD_W-1:0] mods);
		key_event_t ev;
		ev.key  = key;
		ev.mods = mods;
		pending_events.push_back(ev);
	endtask

	// mostly keys from a small pool so presses and releases meet held entries
	task automatic queue_random(int n);
		key_event_t ev;
		int press_pct;
		press_pct = 55;
		for (int k = 0; k < n; k++) begin
			if (k % 40 == 0)
				press_pct = $urandom_range(80, 30);
			if ($urandom_range(99) < 75)
				ev.key = key_pool[$urandom_range(KEY_POOL_SZ - 1)];
			else
				ev.key = 16'($urandom());
			ev.mods            = 16'($urandom());
			ev.mods[PRESS_BIT] = ($urandom_range(99) < press_pct);
			pending_events.push_back(ev);
		end
	endtask

	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			slot_used[i] = 1'b0;
			slot_key[i]  = '0;
			slot_mods[i] = '0;
		end
		for (int i = 0; i < KEY_POOL_SZ; i++)
			key_pool[i] = 16'($urandom());

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: new, repeat, release, unheld release, fill up, drop
		write_repeat_enable(1'b1);
		queue_key(16'h0000, 16'h8000);
		queue_key(16'hFFFF, 16'hFFFF);
		queue_key(16'h0000, 16'hFFFF);
		queue_key(16'hFFFF, 16'h7FFF);
		queue_key(16'h1234, 16'h0000);
		for (int k = 1; k < TABLE_DEPTH; k++)
			queue_key(16'(k), 16'h8000 | 16'(k * 16'h0111));
		queue_key(16'h4242, 16'hC3A5);
		wait_for_drain();

		// directed: suppressed repeat, then a freed slot reused
		write_repeat_enable(1'b0);
		queue_key(16'h0005, 16'h8001);
		queue_key(16'h0000, 16'h0000);
		queue_key(16'h4242, 16'hC3A5);
		wait_for_drain();

		send_idle_pct = 31;
		sink_idle_pct = 58;
		write_repeat_enable(1'b1);
		queue_random(650);
		wait_for_drain();

		send_idle_pct = 58;
		sink_idle_pct = 31;
		write_repeat_enable(1'b0);
		queue_random(650);
		wait_for_drain();

		// no idling; the sink holds off for a long stretch part way through
		send_idle_pct = 0;
		sink_idle_pct = 0;
		stall_at      = results_seen + 30;
		write_repeat_enable(1'b1);
		queue_random(325);
		wait_for_drain();

		write_repeat_enable(1'b0);
		queue_random(325);
		wait_for_drain();

		repeat (8) @(posedge clk);
		if (error_count == 0 && expected_reports.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
